// ----- src/kclc_pkg.sv -----
// ----------------------------------------------------------------------------
// kclc_pkg
// Shared codes for the keypad code lock: result events, door modes, key codes,
// configuration register indexes and the constants of the seconds display.
// ----------------------------------------------------------------------------
package kclc_pkg;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CODE_DIGITS   = 3'd0,
    REG_CODE_LENGTH   = 3'd1,
    REG_MAX_ATTEMPTS  = 3'd2,
    REG_LOCKOUT_TICKS = 3'd3,
    REG_UNLOCK_TICKS  = 3'd4,
    REG_IR_HOLDOFF    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DOOR_IDLE   = 2'd0,
    DOOR_HOLD   = 2'd1,
    DOOR_ARMED  = 2'd2,
    DOOR_CLOSED = 2'd3
  } door_mode_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_DIGIT     = 4'd1,
    EV_CLEARED   = 4'd2,
    EV_BAD_KEY   = 4'd3,
    EV_EMPTY     = 4'd4,
    EV_GRANTED   = 4'd5,
    EV_WRONG     = 4'd6,
    EV_LOCKOUT   = 4'd7,
    EV_AUTO_RST  = 4'd8,
    EV_SENSOR    = 4'd9,
    EV_ARMED     = 4'd10,
    EV_IGNORED   = 4'd11
  } event_t;

  localparam logic       OP_TICK       = 1'b0;
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;
  localparam logic [3:0] FAIL_MAX      = 4'd15;

  // remaining / 1000 as a multiply by a rounded-up reciprocal, exact below 2^16
  localparam logic [32:0] SEC_RECIP = 33'd67109;
  localparam int          SEC_SHIFT = 26;

  localparam logic [31:0] RST_CODE_DIGITS   = 32'd26214;
  localparam logic [3:0]  RST_CODE_LENGTH   = 4'd4;
  localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd3;
  localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd5000;
  localparam logic [15:0] RST_UNLOCK_TICKS  = 16'd3000;
  localparam logic [15:0] RST_IR_HOLDOFF    = 16'd500;

endpackage

// ----- src/keypad_code_lock_controller_unit.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit
// Keypad combination lock with failure lockout, open hold and sensor close.
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one key or tick per cycle; the only limit is the result register,
// and an item is held off only while a finished result is stalled.
// Reset: synchronous rst restores the register defaults and idles the lock;
// no clearing pass, the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_unit #(
  parameter int MAX_DIGITS = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kclc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // item channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      op,
  input  logic [3:0]                key_code,
  input  logic                      ir_low,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      lock_open,
  output logic                      lamp_on,
  output logic                      locked_out,
  output logic [1:0]                door_mode,
  output logic [3:0]                event_res,
  output logic [3:0]                failures,
  output logic [3:0]                digits_entered,
  output logic [6:0]                seconds_left
);
  import kclc_pkg::*;

  localparam int ENTRY_W = 4 * MAX_DIGITS;
  localparam int CNT_W   = $clog2(MAX_DIGITS + 2);
  localparam int CW      = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  // configuration registers
  logic [31:0] code_digits;
  logic [3:0]  code_length;
  logic [3:0]  max_attempts;
  logic [15:0] lockout_ticks;
  logic [15:0] unlock_ticks;
  logic [15:0] ir_holdoff_ticks;

  // controller state
  door_mode_t            mode_reg, mode_next;
  logic [ENTRY_W-1:0]    entry_digits, entry_digits_next;
  logic [CNT_W-1:0]      entry_count, entry_count_next;
  logic [3:0]            failure_count, failure_count_next;
  logic                  lockout_flag, lockout_flag_next;
  logic [TIMER_BITS-1:0] lockout_elapsed, lockout_elapsed_next;
  logic [TIMER_BITS-1:0] hold_elapsed, hold_elapsed_next;
  logic [TIMER_BITS-1:0] sensor_elapsed, sensor_elapsed_next;
  event_t                ev_next;

  logic accept;
  logic cfg_write;

  logic [ENTRY_W+31:0]   code_wide;
  logic [ENTRY_W-1:0]    code_ext;
  logic                  nib_diff;
  logic                  code_match;
  logic [4:0]            cnt5;
  logic [4:0]            cnt5_next;
  logic [4:0]            len5;
  logic [3:0]            fail_inc;
  logic [TIMER_BITS-1:0] lockout_inc;
  logic [TIMER_BITS-1:0] hold_inc;
  logic [TIMER_BITS-1:0] sensor_inc;
  logic [CW-1:0]         lock_el_ext;
  logic [CW-1:0]         lock_lim_ext;
  logic [15:0]           remaining;
  logic [32:0]           sec_prod;
  logic                  open_next;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      code_digits      <= RST_CODE_DIGITS;
      code_length      <= RST_CODE_LENGTH;
      max_attempts     <= RST_MAX_ATTEMPTS;
      lockout_ticks    <= RST_LOCKOUT_TICKS;
      unlock_ticks     <= RST_UNLOCK_TICKS;
      ir_holdoff_ticks <= RST_IR_HOLDOFF;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_CODE_DIGITS:   code_digits      <= pwdata;
        REG_CODE_LENGTH:   code_length      <= pwdata[3:0];
        REG_MAX_ATTEMPTS:  max_attempts     <= pwdata[3:0];
        REG_LOCKOUT_TICKS: lockout_ticks    <= pwdata[15:0];
        REG_UNLOCK_TICKS:  unlock_ticks     <= pwdata[15:0];
        REG_IR_HOLDOFF:    ir_holdoff_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CODE_DIGITS:   prdata = code_digits;
      REG_CODE_LENGTH:   prdata = {28'd0, code_length};
      REG_MAX_ATTEMPTS:  prdata = {28'd0, max_attempts};
      REG_LOCKOUT_TICKS: prdata = {16'd0, lockout_ticks};
      REG_UNLOCK_TICKS:  prdata = {16'd0, unlock_ticks};
      REG_IR_HOLDOFF:    prdata = {16'd0, ir_holdoff_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  // code compare, nibble by nibble up to code_length
  assign code_wide = {{ENTRY_W{1'b0}}, code_digits};
  assign code_ext  = code_wide[ENTRY_W-1:0];
  assign cnt5      = 5'(entry_count);
  assign len5      = {1'b0, code_length};

  always_comb begin
    nib_diff = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((5'(i) < len5) && (entry_digits[4*i +: 4] != code_ext[4*i +: 4])) begin
        nib_diff = 1'b1;
      end
    end
  end

  assign code_match = (code_length != 4'd0) && (len5 <= 5'(MAX_DIGITS)) &&
                      (cnt5 == len5) && !nib_diff;

  assign fail_inc    = (failure_count < FAIL_MAX) ? failure_count + 4'd1 : failure_count;
  assign lockout_inc = sat_inc(lockout_elapsed);
  assign hold_inc    = sat_inc(hold_elapsed);
  assign sensor_inc  = sat_inc(sensor_elapsed);

  always_comb begin
    mode_next            = mode_reg;
    entry_digits_next    = entry_digits;
    entry_count_next     = entry_count;
    failure_count_next   = failure_count;
    lockout_flag_next    = lockout_flag;
    lockout_elapsed_next = lockout_elapsed;
    hold_elapsed_next    = hold_elapsed;
    sensor_elapsed_next  = sensor_elapsed;
    ev_next              = EV_NONE;

    if (op == OP_TICK) begin
      sensor_elapsed_next = sensor_inc;
      if (lockout_flag) begin
        lockout_elapsed_next = lockout_inc;
        if (CW'(lockout_inc) >= CW'(lockout_ticks)) begin
          mode_next            = DOOR_IDLE;
          entry_digits_next    = '0;
          entry_count_next     = '0;
          failure_count_next   = '0;
          lockout_flag_next    = 1'b0;
          lockout_elapsed_next = '0;
          hold_elapsed_next    = '0;
          ev_next              = EV_AUTO_RST;
        end
      end else begin
        case (mode_reg)
          DOOR_HOLD: begin
            hold_elapsed_next = hold_inc;
            if (CW'(hold_inc) >= CW'(unlock_ticks)) begin
              mode_next = DOOR_ARMED;
              ev_next   = EV_ARMED;
            end
          end
          DOOR_ARMED: begin
            if (ir_low && (CW'(sensor_inc) > CW'(ir_holdoff_ticks))) begin
              sensor_elapsed_next = '0;
              mode_next           = DOOR_CLOSED;
              ev_next             = EV_SENSOR;
            end
          end
          default: ;
        endcase
      end
    end else if (lockout_flag) begin
      ev_next = EV_IGNORED;
    end else if (key_code <= KEY_DIGIT_MAX) begin
      if (cnt5 < 5'(MAX_DIGITS)) begin
        entry_digits_next = (entry_digits << 4) | ENTRY_W'(key_code);
        entry_count_next  = entry_count + 1'b1;
      end else begin
        // overlong entry: digits kept, count marks it as never matching
        entry_count_next = CNT_W'(MAX_DIGITS + 1);
      end
      ev_next = EV_DIGIT;
    end else if (key_code == KEY_STAR) begin
      entry_digits_next = '0;
      entry_count_next  = '0;
      ev_next           = EV_CLEARED;
    end else if (key_code == KEY_HASH) begin
      if (entry_count == '0) begin
        ev_next = EV_EMPTY;
      end else if (code_match) begin
        mode_next          = DOOR_HOLD;
        hold_elapsed_next  = '0;
        failure_count_next = '0;
        entry_digits_next  = '0;
        entry_count_next   = '0;
        ev_next            = EV_GRANTED;
      end else begin
        failure_count_next = fail_inc;
        entry_digits_next  = '0;
        entry_count_next   = '0;
        if (fail_inc >= max_attempts) begin
          lockout_flag_next    = 1'b1;
          lockout_elapsed_next = '0;
          ev_next              = EV_LOCKOUT;
        end else begin
          ev_next = EV_WRONG;
        end
      end
    end else begin
      ev_next = EV_BAD_KEY;
    end
  end

  // lockout countdown display
  assign lock_el_ext  = CW'(lockout_elapsed_next);
  assign lock_lim_ext = CW'(lockout_ticks);
  assign remaining    = (lock_el_ext < lock_lim_ext) ? 16'(lock_lim_ext - lock_el_ext) : 16'd0;
  assign sec_prod     = 33'(remaining) * SEC_RECIP;
  assign cnt5_next    = 5'(entry_count_next);
  assign open_next    = (mode_next == DOOR_HOLD) || (mode_next == DOOR_ARMED);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= DOOR_IDLE;
      entry_digits    <= '0;
      entry_count     <= '0;
      failure_count   <= '0;
      lockout_flag    <= 1'b0;
      lockout_elapsed <= '0;
      hold_elapsed    <= '0;
      sensor_elapsed  <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (accept) begin
        mode_reg        <= mode_next;
        entry_digits    <= entry_digits_next;
        entry_count     <= entry_count_next;
        failure_count   <= failure_count_next;
        lockout_flag    <= lockout_flag_next;
        lockout_elapsed <= lockout_elapsed_next;
        hold_elapsed    <= hold_elapsed_next;
        sensor_elapsed  <= sensor_elapsed_next;
        result_valid    <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result beat, no reset needed on payload
  always_ff @(posedge clk) begin
    if (accept) begin
      lock_open      <= open_next;
      lamp_on        <= open_next;
      locked_out     <= lockout_flag_next;
      door_mode      <= mode_next;
      event_res      <= ev_next;
      failures       <= failure_count_next;
      digits_entered <= (cnt5_next > 5'd15) ? 4'd15 : cnt5_next[3:0];
      seconds_left   <= lockout_flag_next ? 7'(sec_prod >> SEC_SHIFT) + 7'd1 : 7'd0;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - keypad code lock controller testbench
// Sends key presses and millisecond ticks with bursty timing against a stalling
// result receiver, and checks every result beat field by field against an
// in-house lock predictor. A short table of directed beats comes first, then
// random entry, submit, tick and noise sequences over several code and timer
// settings, with the timers at both ends of their ranges.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kclc_pkg::*;

  localparam logic       OP_KEY      = ~OP_TICK;
  localparam logic [3:0] DIGITS_MAX  = 4'd8;
  localparam int         CYCLE_LIMIT = 800000;
  localparam int         SHOW_MAX    = 40;

  typedef struct packed {
    logic       op;
    logic [3:0] key;
    logic       ir;
  } lock_item_t;

  typedef struct packed {
    logic       lock_open;
    logic       lamp_on;
    logic       locked_out;
    door_mode_t mode;
    event_t     ev;
    logic [3:0] fails;
    logic [3:0] digits;
    logic [6:0] secs;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic item_valid, item_stall, op, ir_low;
  logic [3:0] key_code;
  logic result_valid, result_stall;
  logic lock_open, lamp_on, locked_out;
  logic [1:0] door_mode;
  logic [3:0] event_res, failures, digits_entered;
  logic [6:0] seconds_left;

  keypad_code_lock_controller_unit u_top (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_stall, .op, .key_code, .ir_low,
    .result_valid, .result_stall,
    .lock_open, .lamp_on, .locked_out, .door_mode, .event_res,
    .failures, .digits_entered, .seconds_left
  );

  always #6 clk = ~clk;

  // lock predictor: register copies and controller state
  logic [31:0] secret_bcd;
  logic [3:0]  secret_len, attempt_limit;
  logic [15:0] lockout_len, hold_len, holdoff_len;
  door_mode_t  door;
  logic [31:0] entry_bcd;
  logic [3:0]  entry_len, wrong_cnt;
  logic        in_lockout;
  logic [15:0] lockout_t, hold_t, sensor_t;

  lock_result_t due_results[$];
  lock_item_t   dir_items[$];
  bit           dir_typed[$];
  lock_result_t dir_want[$];
  bit           row_typed;
  lock_result_t row_want;

  int cycle_count, mismatches, items_sent, items_counted, items_target, results_seen;
  int burst_left;
  int ev_seen[16];
  int stall_style, stall_left;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_lock();
    door       = DOOR_IDLE;
    entry_bcd  = '0;
    entry_len  = '0;
    wrong_cnt  = '0;
    in_lockout = 1'b0;
    lockout_t  = '0;
    hold_t     = '0;
  endfunction

  function automatic lock_result_t advance_lock(lock_item_t it);
    lock_result_t r;
    event_t ev;
    logic [63:0] mask;
    ev = EV_NONE;
    if (it.op != OP_TICK) begin
      mask = (64'd1 << (4 * secret_len)) - 64'd1;
      if (in_lockout) begin
        ev = EV_IGNORED;
      end else if (it.key <= KEY_DIGIT_MAX) begin
        // a digit past the limit marks the entry too long and keeps the digits
        if (entry_len < DIGITS_MAX) begin
          entry_bcd = {entry_bcd[27:0], it.key};
          entry_len = entry_len + 4'd1;
        end else begin
          entry_len = DIGITS_MAX + 4'd1;
        end
        ev = EV_DIGIT;
      end else if (it.key == KEY_STAR) begin
        entry_bcd = '0;
        entry_len = '0;
        ev = EV_CLEARED;
      end else if (it.key == KEY_HASH) begin
        if (entry_len == 0) begin
          ev = EV_EMPTY;
        end else if (secret_len != 0 && secret_len <= DIGITS_MAX && entry_len == secret_len &&
                     ((entry_bcd ^ secret_bcd) & mask[31:0]) == 32'd0) begin
          door      = DOOR_HOLD;
          hold_t    = '0;
          wrong_cnt = '0;
          entry_bcd = '0;
          entry_len = '0;
          ev = EV_GRANTED;
        end else begin
          if (wrong_cnt != FAIL_MAX) wrong_cnt = wrong_cnt + 4'd1;
          entry_bcd = '0;
          entry_len = '0;
          if (wrong_cnt >= attempt_limit) begin
            in_lockout = 1'b1;
            lockout_t  = '0;
            ev = EV_LOCKOUT;
          end else begin
            ev = EV_WRONG;
          end
        end
      end else begin
        ev = EV_BAD_KEY;
      end
    end else begin
      sensor_t = bump(sensor_t);
      if (in_lockout) begin
        // door sequence frozen while locked out
        lockout_t = bump(lockout_t);
        if (lockout_t >= lockout_len) begin
          clear_lock();
          ev = EV_AUTO_RST;
        end
      end else if (door == DOOR_HOLD) begin
        hold_t = bump(hold_t);
        if (hold_t >= hold_len) begin
          door = DOOR_ARMED;
          ev = EV_ARMED;
        end
      end else if (door == DOOR_ARMED && it.ir && sensor_t > holdoff_len) begin
        sensor_t = '0;
        door = DOOR_CLOSED;
        ev = EV_SENSOR;
      end
    end
    r.lock_open  = (door == DOOR_HOLD || door == DOOR_ARMED);
    r.lamp_on    = r.lock_open;
    r.locked_out = in_lockout;
    r.mode       = door;
    r.ev         = ev;
    r.fails      = wrong_cnt;
    r.digits     = entry_len;
    r.secs       = in_lockout ?
                   7'((((lockout_t < lockout_len) ? lockout_len - lockout_t : 16'd0) / 16'd1000)
                      + 16'd1) : 7'd0;
    return r;
  endfunction

  function automatic lock_result_t make_want(logic open, logic lo, door_mode_t m, event_t e,
                                             logic [3:0] f, logic [3:0] d, logic [6:0] s);
    lock_result_t r;
    r = '{open, open, lo, m, e, f, d, s};
    return r;
  endfunction

  function automatic lock_item_t key_item(logic [3:0] k);
    lock_item_t it;
    it.op  = OP_KEY;
    it.key = k;
    it.ir  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic lock_item_t tick_item(logic ir);
    lock_item_t it;
    it.op  = OP_TICK;
    it.key = 4'($urandom_range(0, 15));
    it.ir  = ir;
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < SHOW_MAX)
      $display("[%0t] result beat %0d: %s is %0d, predicted %0d",
               $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(lock_result_t got, lock_result_t want);
    if (got.lock_open !== want.lock_open)
      report_mismatch("lock_open", got.lock_open, want.lock_open);
    if (got.lamp_on !== want.lamp_on)
      report_mismatch("lamp_on", got.lamp_on, want.lamp_on);
    if (got.locked_out !== want.locked_out)
      report_mismatch("locked_out", got.locked_out, want.locked_out);
    if (got.mode !== want.mode)
      report_mismatch("door_mode", got.mode, want.mode);
    if (got.ev !== want.ev)
      report_mismatch("event_res", got.ev, want.ev);
    if (got.fails !== want.fails)
      report_mismatch("wrong count", got.fails, want.fails);
    if (got.digits !== want.digits)
      report_mismatch("digits_entered", got.digits, want.digits);
    if (got.secs !== want.secs)
      report_mismatch("seconds_left", got.secs, want.secs);
  endtask

  // sample both channels at the rising edge; results first, they belong to older beats
  always @(posedge clk) begin : scoreboard
    lock_result_t got, pred;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = '{lock_open, lamp_on, locked_out, door_mode_t'(door_mode), event_t'(event_res),
                failures, digits_entered, seconds_left};
        if (due_results.size() == 0) report_mismatch("result beat with none due", 1, 0);
        else check_result(got, due_results.pop_front());
        results_seen++;
      end
      if (item_valid && !item_stall) begin
        pred = advance_lock('{op, key_code, ir_low});
        ev_seen[pred.ev]++;
        due_results.push_back(row_typed ? row_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls in styles that change whenever a random countdown runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 99) < 30);
      2:       result_stall <= (cycle_count[2:0] == 3'd3 || cycle_count[2:0] == 3'd4);
      default: result_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // called and returns at a falling edge
  task automatic send_item(lock_item_t it);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    if (it.op == OP_TICK || !in_lockout) items_counted++;
    item_valid <= 1'b1;
    op         <= it.op;
    key_code   <= it.key;
    ir_low     <= it.ir;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CODE_DIGITS:   secret_bcd    = val;
      REG_CODE_LENGTH:   secret_len    = val[3:0];
      REG_MAX_ATTEMPTS:  attempt_limit = val[3:0];
      REG_LOCKOUT_TICKS: lockout_len   = val[15:0];
      REG_UNLOCK_TICKS:  hold_len      = val[15:0];
      REG_IR_HOLDOFF:    holdoff_len   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_row(logic o, logic [3:0] k, logic ir, bit typed, lock_result_t w);
    dir_items.push_back('{o, k, ir});
    dir_typed.push_back(typed);
    dir_want.push_back(w);
  endtask

  // one random sequence, shaped by where the lock currently is
  task automatic run_sequence();
    int pick, n;
    pick = $urandom_range(0, 99);
    if (in_lockout) begin
      if (pick < 60) begin
        n = (lockout_t >= lockout_len) ? 1 : int'(lockout_len - lockout_t);
        if (n > 1500) n = 1500;
        // keep long lockouts within what is left of this setting's beats
        if (n > items_target - items_counted) n = items_target - items_counted;
        if (n < 1) n = 1;
        if (pick < 20) n = $urandom_range(1, n);
        repeat (n) send_item(tick_item(1'($urandom_range(0, 1))));
      end else begin
        send_item(key_item(4'($urandom_range(0, 15))));
      end
    end else if (pick < 30) begin
      if (pick < 5) send_item(key_item(KEY_STAR));
      for (int k = int'(secret_len) - 1; k >= 0; k--) send_item(key_item(secret_bcd[4*k +: 4]));
      send_item(key_item(KEY_HASH));
    end else if (pick < 55) begin
      n = (pick < 50) ? $urandom_range(1, 8) : $urandom_range(9, 11);
      repeat (n) send_item(key_item(4'($urandom_range(0, 9))));
      send_item(key_item(KEY_HASH));
    end else if (pick < 80) begin
      n = int'(hold_len) + int'(holdoff_len) + 4;
      if (n > 60) n = 60;
      repeat ($urandom_range(1, n)) send_item(tick_item($urandom_range(0, 99) < 40));
    end else if (pick < 92) begin
      send_item($urandom_range(0, 1) ? key_item(4'($urandom_range(0, 15)))
                                     : tick_item(1'($urandom_range(0, 1))));
    end else if (pick < 99) begin
      repeat ($urandom_range(0, 5)) send_item(key_item(4'($urandom_range(0, 9))));
      send_item(key_item($urandom_range(0, 1) ? KEY_STAR : KEY_HASH));
    end else begin
      // hold off until every due result has come back
      drain();
    end
  endtask

  task automatic run_setting(logic [31:0] code, logic [3:0] len, logic [3:0] att,
                             logic [15:0] lo_t, logic [15:0] un_t, logic [15:0] ho_t, int n);
    drain();
    write_reg(REG_CODE_DIGITS, code);
    write_reg(REG_CODE_LENGTH, {28'd0, len});
    write_reg(REG_MAX_ATTEMPTS, {28'd0, att});
    write_reg(REG_LOCKOUT_TICKS, {16'd0, lo_t});
    write_reg(REG_UNLOCK_TICKS, {16'd0, un_t});
    write_reg(REG_IR_HOLDOFF, {16'd0, ho_t});
    items_counted = 0;
    items_target  = n;
    while (items_counted < n) run_sequence();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item_valid = 1'b0; op = OP_TICK; key_code = '0; ir_low = 1'b0;
    result_stall = 1'b0;
    row_typed = 1'b0; row_want = '0;
    secret_bcd = RST_CODE_DIGITS; secret_len = RST_CODE_LENGTH;
    attempt_limit = RST_MAX_ATTEMPTS; lockout_len = RST_LOCKOUT_TICKS;
    hold_len = RST_UNLOCK_TICKS; holdoff_len = RST_IR_HOLDOFF;
    clear_lock();
    sensor_t = '0;

    // directed beats on the reset settings: code 6666, three tries
    add_row(OP_TICK, 4'd0, 1'b0, 1, make_want(0, 0, DOOR_IDLE, EV_NONE, 0, 0, 0));
    add_row(OP_KEY, 4'd12, 1'b0, 1, make_want(0, 0, DOOR_IDLE, EV_BAD_KEY, 0, 0, 0));
    add_row(OP_KEY, KEY_HASH, 1'b1, 1, make_want(0, 0, DOOR_IDLE, EV_EMPTY, 0, 0, 0));
    add_row(OP_KEY, 4'd6, 1'b0, 0, '0);
    add_row(OP_KEY, KEY_STAR, 1'b0, 1, make_want(0, 0, DOOR_IDLE, EV_CLEARED, 0, 0, 0));
    repeat (4) add_row(OP_KEY, 4'd6, 1'b0, 0, '0);
    add_row(OP_KEY, KEY_HASH, 1'b0, 1, make_want(1, 0, DOOR_HOLD, EV_GRANTED, 0, 0, 0));
    // nine digits: the last one overflows the entry
    for (int i = 0; i < 8; i++) add_row(OP_KEY, (i % 2) ? 4'd9 : 4'd0, 1'b0, 0, '0);
    add_row(OP_KEY, 4'd9, 1'b1, 0, '0);
    add_row(OP_KEY, KEY_HASH, 1'b0, 1, make_want(1, 0, DOOR_HOLD, EV_WRONG, 1, 0, 0));
    add_row(OP_KEY, 4'd1, 1'b0, 0, '0);
    add_row(OP_KEY, KEY_HASH, 1'b0, 0, '0);
    add_row(OP_KEY, 4'd3, 1'b0, 0, '0);
    add_row(OP_KEY, KEY_HASH, 1'b0, 1, make_want(1, 1, DOOR_HOLD, EV_LOCKOUT, 3, 0, 6));
    add_row(OP_KEY, 4'd15, 1'b1, 1, make_want(1, 1, DOOR_HOLD, EV_IGNORED, 3, 0, 6));
    add_row(OP_TICK, 4'd15, 1'b1, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_items[i]) begin
      row_typed = dir_typed[i];
      row_want  = dir_want[i];
      send_item(dir_items[i]);
    end
    row_typed = 1'b0;

    run_setting(32'h0000_1234, 4'd4, 4'd3, 16'd20, 16'd12, 16'd5, 400);
    run_setting(32'h0000_0009, 4'd1, 4'd1, 16'd1, 16'd1, 16'd0, 320);
    run_setting(32'h9876_5432, 4'd8, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 150);
    // non-decimal code nibbles, so no entry can ever match
    run_setting(32'hFFFF_FFFF, 4'd8, 4'd2, 16'd9, 16'd3, 16'd2, 220);
    run_setting(32'h0000_0000, 4'd3, 4'd15, 16'd40, 16'd25, 16'd10, 400);
    run_setting(32'h0507_3801, 4'd6, 4'd2, 16'd1200, 16'd8, 16'd3, 300);

    drain();
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) report_mismatch("results never delivered", due_results.size(), 0);

    $display("covered %0d input beats and %0d result beats over seven register settings",
             items_sent, results_seen);
    $display("grants %0d, lockouts %0d, auto resets %0d, armed %0d, sensor closes %0d, ignored %0d",
             ev_seen[EV_GRANTED], ev_seen[EV_LOCKOUT], ev_seen[EV_AUTO_RST],
             ev_seen[EV_ARMED], ev_seen[EV_SENSOR], ev_seen[EV_IGNORED]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/kclc_pkg.sv
src/keypad_code_lock_controller_unit.sv
tb/tb_top.sv
